// ----- src/mipsx_pkg.sv -----
// Shared constants for the MIPS-subset execute unit: opcodes, function codes,
// field widths and default sizes. No dependencies.
package mipsx_pkg;

  // Primary opcodes
  localparam logic [5:0] OP_RTYPE = 6'd0;
  localparam logic [5:0] OP_J     = 6'd2;
  localparam logic [5:0] OP_BEQ   = 6'd4;
  localparam logic [5:0] OP_ADDI  = 6'd8;
  localparam logic [5:0] OP_LW    = 6'd35;
  localparam logic [5:0] OP_SW    = 6'd43;

  // R-type function codes
  localparam logic [5:0] FN_ADD = 6'd32;
  localparam logic [5:0] FN_SUB = 6'd34;
  localparam logic [5:0] FN_AND = 6'd36;
  localparam logic [5:0] FN_OR  = 6'd37;
  localparam logic [5:0] FN_SLT = 6'd42;

  // Sizes
  localparam int REG_COUNT    = 32;
  localparam int REG_AW       = 5;
  localparam int MEM_WORDS_DEF = 256;
  localparam int WORD_W       = 32;
  localparam int LEN_W        = 16;

  // Stream widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 72;

endpackage

// ----- src/mipsx_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mipsx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/mips_subset_execute_pc_unit.sv -----
// Top level of the MIPS-subset execute unit: register file, data memory, PC.
// Depends on mipsx_pkg and mipsx_ram.
//
// Usage:
//   s_axis_* carries one decoded instruction per item; m_axis_* returns one
//   result item per instruction, in order. cfg_* writes program_length; write
//   it only while the unit is idle.
//   A result passes the input register, then a result register that also
//   holds the data memory read. Throughput: one instruction per cycle while
//   m_axis_tready is high, back to back, including dependent instructions
//   and loads followed by their users; register results are forwarded from
//   the result stage and from the last write.
//   Reset: the register file and data memory are swept to zero, one entry
//   per cycle; the input side is not ready during the sweep, configuration
//   writes are taken.
//   Stall: when the receiver holds m_axis_tready low, the result stays put;
//   one more instruction is still taken into the execute stage only if it is
//   empty, and s_axis_tready stays low until the result moves on.
//   MEM_WORDS must be a power of two; the word index is the low bits of the
//   arithmetically shifted address.
module mips_subset_execute_pc_unit #(
  parameter int MEM_WORDS = mipsx_pkg::MEM_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // tdata: opcode_field[5:0], src_reg[10:6], tgt_reg[15:11], dst_reg[20:16],
  //        func_code[26:21], imm_value[42:27], jump_target[68:43], zero pad
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [mipsx_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  // tdata: next_pc[31:0], reg_written[32], written_reg[37:33],
  //        written_value[69:38], branch_taken[70], finished[71]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [mipsx_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // program_length
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [mipsx_pkg::LEN_W-1:0] cfg_data
);

  localparam int AW      = $clog2(MEM_WORDS);
  localparam int CLR_LEN = (MEM_WORDS > mipsx_pkg::REG_COUNT) ? MEM_WORDS
                                                                : mipsx_pkg::REG_COUNT;
  localparam int CW      = $clog2(CLR_LEN);
  localparam int W       = mipsx_pkg::WORD_W;
  localparam int RW      = mipsx_pkg::REG_AW;

  // Configuration
  logic [mipsx_pkg::LEN_W-1:0] program_length;

  // Clear sweep
  logic          clearing;
  logic [CW-1:0] clr_cnt;

  // Execute stage
  logic          s1_valid;
  logic [5:0]    s1_op;
  logic [RW-1:0] s1_rs;
  logic [RW-1:0] s1_rt;
  logic [RW-1:0] s1_rd;
  logic [5:0]    s1_fn;
  logic [15:0]   s1_imm;
  logic [25:0]   s1_tgt;

  // Result stage
  logic          s2_valid;
  logic [W-1:0]  s2_pc;
  logic          s2_wr;
  logic [RW-1:0] s2_wreg;
  logic [W-1:0]  s2_val;
  logic          s2_taken;
  logic          s2_fin;
  logic          s2_lw;
  logic [W-1:0]  s2_final;

  // Last register write, tied to the register file read issued at that edge
  logic          lw_valid;
  logic [RW-1:0] lw_idx;
  logic [W-1:0]  lw_val;

  logic [W-1:0]  pc;

  // Handshake and stage enables
  logic adv;
  logic s1_en;
  logic out_fire;

  // RAM ports
  logic          rf_we;
  logic [RW-1:0] rf_waddr;
  logic [W-1:0]  rf_wdata;
  logic [W-1:0]  rf_rdata_a;
  logic [W-1:0]  rf_rdata_b;
  logic          dm_we;
  logic [AW-1:0] dm_waddr;
  logic [W-1:0]  dm_wdata;
  logic [W-1:0]  dm_rdata;

  // Execute results
  logic [W-1:0]  op_a;
  logic [W-1:0]  op_b;
  logic [W-1:0]  addr_sum;
  logic [W-1:0]  addr_sh;
  logic [AW-1:0] mem_idx;
  logic [W-1:0]  pc_next;
  logic          wr_next;
  logic [RW-1:0] wreg_next;
  logic [W-1:0]  val_next;
  logic          taken_next;
  logic          lw_next;
  logic          sw_next;

  assign adv           = !s2_valid || m_axis_tready;
  assign s1_en         = adv || !s1_valid;
  assign s_axis_tready = s1_en && !clearing;
  assign out_fire      = s2_valid && m_axis_tready;
  assign cfg_ready     = 1'b1;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      program_length <= '0;
    end else if (cfg_valid) begin
      program_length <= cfg_data;
    end
  end

  // Clear sweep after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == CW'(CLR_LEN - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Register file: two copies, one per read port, written together
  assign rf_we    = clearing ? ({{(32-CW){1'b0}}, clr_cnt} < 32'(mipsx_pkg::REG_COUNT))
                             : (out_fire && s2_wr);
  assign rf_waddr = clearing ? clr_cnt[RW-1:0] : s2_wreg;
  assign rf_wdata = clearing ? '0 : s2_final;

  mipsx_ram #(
    .WIDTH (W),
    .DEPTH (mipsx_pkg::REG_COUNT)
  ) u_rf_a (
    .clk     (clk),
    .wr_en   (rf_we),
    .wr_addr (rf_waddr),
    .wr_data (rf_wdata),
    .rd_en   (s1_en),
    .rd_addr (s_axis_tdata[10:6]),
    .rd_data (rf_rdata_a)
  );

  mipsx_ram #(
    .WIDTH (W),
    .DEPTH (mipsx_pkg::REG_COUNT)
  ) u_rf_b (
    .clk     (clk),
    .wr_en   (rf_we),
    .wr_addr (rf_waddr),
    .wr_data (rf_wdata),
    .rd_en   (s1_en),
    .rd_addr (s_axis_tdata[15:11]),
    .rd_data (rf_rdata_b)
  );

  // Data memory: stores and loads issue as the item leaves execute
  assign dm_we    = clearing ? ({{(32-CW){1'b0}}, clr_cnt} < 32'(MEM_WORDS))
                             : (adv && s1_valid && sw_next);
  assign dm_waddr = clearing ? clr_cnt[AW-1:0] : mem_idx;
  assign dm_wdata = clearing ? '0 : op_b;

  mipsx_ram #(
    .WIDTH (W),
    .DEPTH (MEM_WORDS)
  ) u_dmem (
    .clk     (clk),
    .wr_en   (dm_we),
    .wr_addr (dm_waddr),
    .wr_data (dm_wdata),
    .rd_en   (adv),
    .rd_addr (mem_idx),
    .rd_data (dm_rdata)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_en) begin
      s1_valid <= s_axis_tvalid && s_axis_tready;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_op  <= s_axis_tdata[5:0];
      s1_rs  <= s_axis_tdata[10:6];
      s1_rt  <= s_axis_tdata[15:11];
      s1_rd  <= s_axis_tdata[20:16];
      s1_fn  <= s_axis_tdata[26:21];
      s1_imm <= s_axis_tdata[42:27];
      s1_tgt <= s_axis_tdata[68:43];
    end
  end

  // Record the write made at each read edge of the register file
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (s1_en) begin
      lw_valid <= out_fire && s2_wr;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      lw_idx <= s2_wreg;
      lw_val <= s2_final;
    end
  end

  // Result of the item in the result stage, load data included
  assign s2_final = s2_lw ? dm_rdata : s2_val;

  // Operand forwarding: result stage first, then the last write
  always_comb begin
    if (s2_valid && s2_wr && (s2_wreg == s1_rs)) begin
      op_a = s2_final;
    end else if (lw_valid && (lw_idx == s1_rs)) begin
      op_a = lw_val;
    end else begin
      op_a = rf_rdata_a;
    end
    if (s2_valid && s2_wr && (s2_wreg == s1_rt)) begin
      op_b = s2_final;
    end else if (lw_valid && (lw_idx == s1_rt)) begin
      op_b = lw_val;
    end else begin
      op_b = rf_rdata_b;
    end
  end

  // Word address: (rs + imm) shifted right arithmetically, low bits kept
  assign addr_sum = op_a + {16'b0, s1_imm};
  assign addr_sh  = {{2{addr_sum[W-1]}}, addr_sum[W-1:2]};
  assign mem_idx  = addr_sh[AW-1:0];

  // Decode and execute
  always_comb begin
    pc_next    = pc + 32'd1;
    wr_next    = 1'b0;
    wreg_next  = '0;
    val_next   = '0;
    taken_next = 1'b0;
    lw_next    = 1'b0;
    sw_next    = 1'b0;
    unique case (s1_op)
      mipsx_pkg::OP_ADDI: begin
        wr_next   = 1'b1;
        wreg_next = s1_rt;
        val_next  = addr_sum;
      end
      mipsx_pkg::OP_LW: begin
        wr_next   = 1'b1;
        wreg_next = s1_rt;
        lw_next   = 1'b1;
      end
      mipsx_pkg::OP_SW: begin
        sw_next  = 1'b1;
        val_next = op_b;
      end
      mipsx_pkg::OP_BEQ: begin
        if (op_a == op_b) begin
          taken_next = 1'b1;
          pc_next    = pc + {16'b0, s1_imm} + 32'd1;
        end else begin
          pc_next = pc + 32'd2;
        end
      end
      mipsx_pkg::OP_J: begin
        taken_next = 1'b1;
        pc_next    = {6'b0, s1_tgt};
      end
      mipsx_pkg::OP_RTYPE: begin
        wr_next   = 1'b1;
        wreg_next = s1_rd;
        unique case (s1_fn)
          mipsx_pkg::FN_ADD: val_next = op_a + op_b;
          mipsx_pkg::FN_SUB: val_next = op_a - op_b;
          mipsx_pkg::FN_AND: val_next = op_a & op_b;
          mipsx_pkg::FN_OR:  val_next = op_a | op_b;
          mipsx_pkg::FN_SLT: val_next = {31'b0, $signed(op_a) < $signed(op_b)};
          default:           wr_next  = 1'b0;
        endcase
      end
      default: begin
        wr_next = 1'b0;
      end
    endcase
    // Drop writes to register zero and report them as no write
    if (wr_next && (wreg_next == '0)) begin
      wr_next = 1'b0;
    end
    if (!wr_next) begin
      wreg_next = '0;
      lw_next   = 1'b0;
      if (!sw_next) begin
        val_next = '0;
      end
    end
  end

  // Program counter: advance as the item leaves execute
  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
    end else if (adv && s1_valid) begin
      pc <= pc_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_pc    <= pc_next;
      s2_wr    <= wr_next && s1_valid;
      s2_wreg  <= wreg_next;
      s2_val   <= val_next;
      s2_taken <= taken_next;
      s2_fin   <= pc_next >= {16'b0, program_length};
      s2_lw    <= lw_next;
    end
  end

  assign m_axis_tvalid = s2_valid;
  assign m_axis_tdata  = {s2_fin, s2_taken, s2_final, s2_wreg, s2_wr, s2_pc};

  // Checks
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s2_valid |-> pc == s2_pc)
    else $error("pc does not follow the result stage");

  assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_wr |-> s2_wreg != '0)
    else $error("write to register zero reported");

  assert property (@(posedge clk) disable iff (rst)
    s2_valid && !s2_wr |-> s2_wreg == '0 && !s2_lw)
    else $error("no-write result carries a register number");

  assert property (@(posedge clk) disable iff (rst)
    s2_valid && s2_taken |-> !s2_wr)
    else $error("taken branch also wrote a register");

  assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_valid && !s2_valid)
    else $error("item in flight during clear sweep");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking bench for mips_subset_execute_pc_unit: random and directed instructions
// are checked against an in-bench execution model of registers, memory and PC.
// Depends on mipsx_pkg and the unit's RTL.
module testbench;

  localparam int MEM_WORDS = mipsx_pkg::MEM_WORDS_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 285;

  // decoded instruction, opcode in the low bits as on s_axis_tdata
  typedef struct packed {
    logic [25:0] tgt;
    logic [15:0] imm;
    logic [5:0]  fn;
    logic [4:0]  rd;
    logic [4:0]  rt;
    logic [4:0]  rs;
    logic [5:0]  op;
  } instr_t;

  // execution result, next PC in the low bits as on m_axis_tdata
  typedef struct packed {
    logic        fin;
    logic        taken;
    logic [31:0] wval;
    logic [4:0]  wreg;
    logic        wr;
    logic [31:0] npc;
  } exec_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [mipsx_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [mipsx_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [mipsx_pkg::LEN_W-1:0] cfg_data = '0;

  // architectural state of the execution model
  logic [31:0] gpr [mipsx_pkg::REG_COUNT] = '{default: '0};
  logic [31:0] dmem [MEM_WORDS] = '{default: '0};
  logic [31:0] pc = '0;
  logic [15:0] prog_len = '0;

  instr_t instr_queue[$];
  exec_result_t expected_results[$];
  instr_t cur_instr;
  int outstanding = 0;
  int mismatches = 0;
  int results_seen = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit quiet = 1'b0;

  mips_subset_execute_pc_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Execute one instruction on the model state and return its result.
  function automatic exec_result_t execute_instr(instr_t ins);
    exec_result_t r;
    logic [31:0] a, b, addr;
    int idx;
    logic wr;
    a = (ins.rs == 0) ? 32'd0 : gpr[ins.rs];
    b = (ins.rt == 0) ? 32'd0 : gpr[ins.rt];
    addr = $signed(a + {16'h0, ins.imm}) >>> 2;
    idx = addr % MEM_WORDS;
    r = '0;
    r.npc = pc + 32'd1;
    wr = 1'b0;
    case (ins.op)
      mipsx_pkg::OP_ADDI: begin
        wr = 1'b1;
        r.wreg = ins.rt;
        r.wval = a + {16'h0, ins.imm};
      end
      mipsx_pkg::OP_LW: begin
        wr = 1'b1;
        r.wreg = ins.rt;
        r.wval = dmem[idx];
      end
      mipsx_pkg::OP_SW: begin
        dmem[idx] = b;
        r.wval = b;
      end
      mipsx_pkg::OP_BEQ: begin
        if (a == b) begin
          r.taken = 1'b1;
          r.npc = pc + {16'h0, ins.imm} + 32'd1;
        end else begin
          r.npc = pc + 32'd2;
        end
      end
      mipsx_pkg::OP_J: begin
        r.taken = 1'b1;
        r.npc = {6'h0, ins.tgt};
      end
      mipsx_pkg::OP_RTYPE: begin
        wr = 1'b1;
        r.wreg = ins.rd;
        case (ins.fn)
          mipsx_pkg::FN_ADD: r.wval = a + b;
          mipsx_pkg::FN_SUB: r.wval = a - b;
          mipsx_pkg::FN_AND: r.wval = a & b;
          mipsx_pkg::FN_OR:  r.wval = a | b;
          mipsx_pkg::FN_SLT: r.wval = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
          default: wr = 1'b0;
        endcase
      end
      default: ;
    endcase
    // drop writes to register zero and unknown functions
    if (wr && r.wreg != 0) begin
      gpr[r.wreg] = r.wval;
      r.wr = 1'b1;
    end else begin
      r.wreg = '0;
      if (ins.op != mipsx_pkg::OP_SW) r.wval = '0;
    end
    pc = r.npc;
    r.fin = (r.npc >= {16'h0, prog_len});
    return r;
  endfunction

  function automatic instr_t mk_instr(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                      logic [4:0] rd, logic [5:0] fn, logic [15:0] imm,
                                      logic [25:0] tgt);
    instr_t ins;
    ins.op = op;
    ins.rs = rs;
    ins.rt = rt;
    ins.rd = rd;
    ins.fn = fn;
    ins.imm = imm;
    ins.tgt = tgt;
    return ins;
  endfunction

  // Favor the low registers so results feed later instructions.
  function automatic logic [4:0] pick_reg();
    return $urandom_range(1) ? 5'($urandom_range(7)) : 5'($urandom_range(31));
  endfunction

  function automatic instr_t random_instr();
    instr_t ins;
    int pick;
    ins = mk_instr(6'($urandom_range(63)), pick_reg(), pick_reg(), pick_reg(),
                   6'($urandom_range(63)), 16'($urandom_range(16'hFFFF)),
                   26'($urandom_range(26'h3FFFFFF)));
    pick = $urandom_range(99);
    if (pick < 18) begin
      ins.op = mipsx_pkg::OP_ADDI;
    end else if (pick < 42) begin
      ins.op = mipsx_pkg::OP_RTYPE;
      if (pick < 38) begin
        case ($urandom_range(4))
          0: ins.fn = mipsx_pkg::FN_ADD;
          1: ins.fn = mipsx_pkg::FN_SUB;
          2: ins.fn = mipsx_pkg::FN_AND;
          3: ins.fn = mipsx_pkg::FN_OR;
          default: ins.fn = mipsx_pkg::FN_SLT;
        endcase
      end
    end else if (pick < 70) begin
      // keep many addresses near each other so loads hit earlier stores
      ins.op = (pick < 56) ? mipsx_pkg::OP_SW : mipsx_pkg::OP_LW;
      if ($urandom_range(1)) ins.imm = 16'($urandom_range(1023));
      if ($urandom_range(4) == 0) ins.rs = '0;
    end else if (pick < 82) begin
      ins.op = mipsx_pkg::OP_BEQ;
      if ($urandom_range(4) < 2) ins.rt = ins.rs;
    end else if (pick < 90) begin
      ins.op = mipsx_pkg::OP_J;
      if ($urandom_range(1)) ins.tgt = 26'($urandom_range(70000));
    end else begin
      do begin
        ins.op = 6'($urandom_range(63));
      end while (ins.op inside {mipsx_pkg::OP_RTYPE, mipsx_pkg::OP_J, mipsx_pkg::OP_BEQ,
                                mipsx_pkg::OP_ADDI, mipsx_pkg::OP_LW, mipsx_pkg::OP_SW});
    end
    return ins;
  endfunction

  task automatic send(instr_t ins);
    instr_queue.push_back(ins);
    outstanding++;
  endtask

  // Write program_length and wait for the handshake; call at a clock edge.
  task automatic write_length(logic [15:0] len);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    do @(posedge clk); while (!cfg_ready);
    prog_len = len;
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drain();
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, seen);
      mismatches++;
    end
  endtask

  // Stimulus: directed program, then random phases under several lengths.
  initial begin
    logic [15:0] lengths [5];
    lengths = '{16'd0, 16'hFFFF, 16'($urandom_range(1, 65534)), 16'd40, 16'hFFFF};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    write_length(16'd3);

    send(mk_instr(mipsx_pkg::OP_ADDI, 0, 1, 0, 0, 16'hFFFF, 0));
    send(mk_instr(mipsx_pkg::OP_ADDI, 1, 0, 0, 0, 16'd5, 0));
    send(mk_instr(mipsx_pkg::OP_RTYPE, 0, 1, 3, mipsx_pkg::FN_SUB, 0, 0));
    send(mk_instr(mipsx_pkg::OP_RTYPE, 1, 1, 4, mipsx_pkg::FN_ADD, 0, 0));
    send(mk_instr(mipsx_pkg::OP_RTYPE, 3, 1, 5, mipsx_pkg::FN_AND, 0, 0));
    send(mk_instr(mipsx_pkg::OP_RTYPE, 3, 1, 6, mipsx_pkg::FN_OR, 0, 0));
    send(mk_instr(mipsx_pkg::OP_RTYPE, 3, 1, 7, mipsx_pkg::FN_SLT, 0, 0));
    send(mk_instr(mipsx_pkg::OP_RTYPE, 1, 3, 8, mipsx_pkg::FN_SLT, 0, 0));
    send(mk_instr(mipsx_pkg::OP_RTYPE, 1, 1, 9, 6'd0, 0, 0));
    send(mk_instr(mipsx_pkg::OP_RTYPE, 1, 1, 0, mipsx_pkg::FN_ADD, 0, 0));
    // negative base address shifts in sign bits
    send(mk_instr(mipsx_pkg::OP_SW, 3, 1, 0, 0, 16'd0, 0));
    send(mk_instr(mipsx_pkg::OP_LW, 3, 10, 0, 0, 16'd0, 0));
    send(mk_instr(mipsx_pkg::OP_LW, 0, 11, 0, 0, 16'h0400, 0));
    send(mk_instr(mipsx_pkg::OP_SW, 0, 4, 0, 0, 16'hFFFF, 0));
    send(mk_instr(mipsx_pkg::OP_LW, 0, 0, 0, 0, 16'hFFFF, 0));
    send(mk_instr(mipsx_pkg::OP_LW, 0, 12, 0, 0, 16'hFFFF, 0));
    send(mk_instr(mipsx_pkg::OP_BEQ, 0, 0, 0, 0, 16'hFFFF, 0));
    send(mk_instr(mipsx_pkg::OP_BEQ, 1, 3, 0, 0, 16'd7, 0));
    send(mk_instr(mipsx_pkg::OP_J, 0, 0, 0, 0, 0, 26'h3FFFFFF));
    send(mk_instr(mipsx_pkg::OP_J, 0, 0, 0, 0, 0, 26'd0));
    send(mk_instr(6'd63, 31, 31, 31, 6'd63, 16'hFFFF, 26'h3FFFFFF));
    send(mk_instr(6'd1, 1, 1, 1, mipsx_pkg::FN_ADD, 16'd1, 26'd1));
    send(mk_instr(mipsx_pkg::OP_ADDI, 31, 31, 0, 0, 16'h8000, 0));
    send(mk_instr(mipsx_pkg::OP_J, 0, 0, 0, 0, 0, 26'd1));
    send(mk_instr(mipsx_pkg::OP_ADDI, 0, 2, 0, 0, 16'd1, 0));
    send(mk_instr(mipsx_pkg::OP_ADDI, 2, 2, 0, 0, 16'd1, 0));
    wait_drain();

    foreach (lengths[p]) begin
      write_length(lengths[p]);
      quiet = (p == 1);
      repeat (PHASE_ITEMS) send(random_instr());
      wait_drain();
    end
    quiet = 1'b0;

    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Driver: present queued instructions, predict each one on acceptance.
  always @(posedge clk) begin : instr_drive
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(execute_instr(cur_instr));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (instr_queue.size() != 0 && (quiet || $urandom_range(99) >= 13)) begin
          cur_instr = instr_queue.pop_front();
          s_axis_tdata <= {3'b000, cur_instr};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Hold off the receiver once for a long stretch so the unit backs up its input
  always @(posedge clk) begin : hold_count
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= 450) begin
      hold_done <= 1'b1;
      hold_left <= 80;
    end
  end

  // Monitor: compare each result item with the oldest prediction.
  always @(posedge clk) begin : result_mon
    exec_result_t got, want;
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        results_seen++;
        if (expected_results.size() == 0) begin
          $error("result item with no instruction outstanding: 0x%018h", m_axis_tdata);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          outstanding--;
          check_field("next_pc", want.npc, got.npc);
          check_field("reg_written", 32'(want.wr), 32'(got.wr));
          check_field("written_reg", 32'(want.wreg), 32'(got.wreg));
          check_field("written_value", want.wval, got.wval);
          check_field("branch_taken", 32'(want.taken), 32'(got.taken));
          check_field("finished", 32'(want.fin), 32'(got.fin));
        end
      end
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= quiet || ($urandom_range(99) >= 13);
      end
    end
  end

  // Timeout
  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- mips_subset_execute_pc_unit.f -----
src/mipsx_pkg.sv
src/mipsx_ram.sv
src/mips_subset_execute_pc_unit.sv
tb/sv/testbench.sv
